### sv/assert_macros.svh
// assertion macros used by the back end
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check sampled on the rising clock edge, muted in reset
`define RAU_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("rau assertion failed");

// check that an implication holds in the cycle after the antecedent
`define RAU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rau assertion failed");

`endif

### sv/rau_pkg.sv
// types and codes of the rational arithmetic unit
`default_nettype none
package rau_pkg;
    localparam int MAG_W = 32;

    localparam logic [2:0] OP_NORM = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;
    localparam logic [2:0] OP_CMP  = 3'd5;
    localparam logic [2:0] OP_NEG  = 3'd6;
    localparam logic [2:0] OP_ABS  = 3'd7;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_WIDE = 2'd2;

    typedef struct packed {
        logic [2:0]       op;
        logic             err;
        logic             a_neg;
        logic [MAG_W-1:0] a_mag;
        logic [MAG_W-1:0] a_den;
        logic             b_neg;
        logic [MAG_W-1:0] b_mag;
        logic [MAG_W-1:0] b_den;
    } t_job;
endpackage
`default_nettype wire

### sv/rau_if.sv
// handshake interfaces of the input and result channels
`default_nettype none
interface rau_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
    modport source (output valid, operation, a_num, a_den, b_num, b_den, input ready);
    modport sink (input valid, operation, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
    logic        valid;
    logic        ready;
    logic signed [63:0] result_num;
    logic [62:0] result_den;
    logic        less;
    logic        equal;
    logic        greater;
    logic [1:0]  status;
    modport source (output valid, result_num, result_den, less, equal, greater, status,
                    input ready);
    modport sink (input valid, result_num, result_den, less, equal, greater, status,
                  output ready);
endinterface
`default_nettype wire

### sv/rau_front.sv
// front end: accepts transactions and classifies operands
`default_nettype none
module rau_front import rau_pkg::*; #(
    parameter int OPERAND_BITS = 32
) (
    rau_in_if.sink   i_in,
    input  wire      i_full,
    output logic     o_push,
    output t_job     o_job
);
    function automatic logic [MAG_W:0] sext(input logic [31:0] v);
        logic [OPERAND_BITS-1:0] f;
        f = v[OPERAND_BITS-1:0];
        return {{(MAG_W+1-OPERAND_BITS){f[OPERAND_BITS-1]}}, f};
    endfunction

    logic [MAG_W:0] an, ad, bn, bd;
    logic [MAG_W:0] an_m, ad_m, bn_m, bd_m;
    logic           uses_b;

    always_comb begin
        an = sext(i_in.a_num);
        ad = sext(i_in.a_den);
        bn = sext(i_in.b_num);
        bd = sext(i_in.b_den);
        an_m = an[MAG_W] ? ((MAG_W+1)'(0) - an) : an;
        ad_m = ad[MAG_W] ? ((MAG_W+1)'(0) - ad) : ad;
        bn_m = bn[MAG_W] ? ((MAG_W+1)'(0) - bn) : bn;
        bd_m = bd[MAG_W] ? ((MAG_W+1)'(0) - bd) : bd;
        uses_b = (i_in.operation >= OP_ADD) && (i_in.operation <= OP_CMP);
        o_job.op    = i_in.operation;
        o_job.err   = (ad == '0) || (uses_b && bd == '0)
                    || (i_in.operation == OP_DIV && bn == '0);
        o_job.a_neg = an[MAG_W] ^ ad[MAG_W];
        o_job.a_mag = an_m[MAG_W-1:0];
        o_job.a_den = ad_m[MAG_W-1:0];
        // b is not used by single-operand operations
        o_job.b_neg = uses_b & (bn[MAG_W] ^ bd[MAG_W]);
        o_job.b_mag = uses_b ? bn_m[MAG_W-1:0] : '0;
        o_job.b_den = uses_b ? bd_m[MAG_W-1:0] : MAG_W'(1);
    end

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;
endmodule
`default_nettype wire

### sv/rau_fifo.sv
// two-entry job queue between front and back end
`default_nettype none
module rau_fifo import rau_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_push,
    input  t_job i_job,
    input  wire  i_pop,
    output logic o_full,
    output logic o_valid,
    output t_job o_job
);
    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_job   = r_mem[r_rp];
endmodule
`default_nettype wire

### sv/rau_back.sv
// back end: sequencer with binary gcd, restoring divider and shared multiplier
`default_nettype none
module rau_back import rau_pkg::*; #(
    parameter int OPERAND_BITS = 32
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_job_valid,
    input  t_job      i_job,
    output logic      o_pop,
    rau_out_if.source o_out
);
    `include "assert_macros.svh"

    localparam logic [63:0] LIM = 64'd1 << (OPERAND_BITS - 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_GCD  = 4'd1;
    localparam logic [3:0] S_DIV1 = 4'd2;
    localparam logic [3:0] S_DIV2 = 4'd3;
    localparam logic [3:0] S_NEXT = 4'd4;
    localparam logic [3:0] S_MUL  = 4'd5;
    localparam logic [3:0] S_COMB = 4'd6;
    localparam logic [3:0] S_DONE = 4'd7;

    localparam logic [1:0] P_A = 2'd0;
    localparam logic [1:0] P_B = 2'd1;
    localparam logic [1:0] P_R = 2'd2;

    logic [3:0]       r_state;
    logic [1:0]       r_phase;
    logic [2:0]       r_op;
    logic             r_aneg, r_bneg, r_wneg;
    logic [MAG_W-1:0] r_am, r_ad, r_bm, r_bd;
    logic [MAG_W-1:0] r_bm_in, r_bd_in;
    logic             r_bneg_in;
    logic [63:0]      r_m, r_d, r_x, r_y, r_g, r_q, r_r;
    logic [5:0]       r_k, r_cnt;
    logic [63:0]      r_p [4];
    logic             r_lt, r_eq, r_gt;
    logic [1:0]       r_st;

    logic [MAG_W-1:0] mul_a, mul_b;
    logic [64:0]      rem_sh;
    logic             q_bit;
    logic             out_free;
    logic             t2_neg, add_neg;
    logic [63:0]      add_mag;
    logic signed [63:0] cmp_l, cmp_g;
    logic             res_neg;
    logic [63:0]      fin_num;

    assign out_free = !o_out.valid || o_out.ready;
    assign o_pop    = (r_state == S_IDLE) && i_job_valid;

    always_comb begin
        unique case (r_cnt[1:0])
            2'd0: begin mul_a = r_am; mul_b = r_bd; end
            2'd1: begin mul_a = r_bm; mul_b = r_ad; end
            2'd2: begin mul_a = r_ad; mul_b = r_bd; end
            default: begin mul_a = r_am; mul_b = r_bm; end
        endcase
        rem_sh = {r_r, r_q[63]};
        q_bit  = rem_sh >= {1'b0, r_g};
        // add and subtract in sign-magnitude form
        t2_neg = ((r_op == OP_SUB) ? !r_bneg : r_bneg) && (r_p[1] != '0);
        if (r_aneg == t2_neg) begin
            add_mag = r_p[0] + r_p[1];
            add_neg = r_aneg;
        end else if (r_p[0] >= r_p[1]) begin
            add_mag = r_p[0] - r_p[1];
            add_neg = r_aneg;
        end else begin
            add_mag = r_p[1] - r_p[0];
            add_neg = t2_neg;
        end
        cmp_l = r_aneg ? -$signed(r_p[0]) : $signed(r_p[0]);
        cmp_g = r_bneg ? -$signed(r_p[1]) : $signed(r_p[1]);
        res_neg = r_wneg && (r_m != '0);
        fin_num = res_neg ? (64'd0 - r_m) : r_m;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= P_A;
            o_out.valid <= 1'b0;
        end else begin
            // a result taken while a new one is loaded keeps valid high
            if (o_out.valid && o_out.ready && r_state != S_DONE) o_out.valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_op <= i_job.op;
                        r_bm_in <= i_job.b_mag;
                        r_bd_in <= i_job.b_den;
                        r_bneg_in <= i_job.b_neg;
                        r_lt <= 1'b0;
                        r_eq <= 1'b0;
                        r_gt <= 1'b0;
                        if (i_job.err) begin
                            r_m <= '0;
                            r_d <= '0;
                            r_wneg <= 1'b0;
                            r_st <= ST_ZERO;
                            r_state <= S_DONE;
                        end else begin
                            r_m <= 64'(i_job.a_mag);
                            r_d <= 64'(i_job.a_den);
                            r_x <= 64'(i_job.a_mag);
                            r_y <= 64'(i_job.a_den);
                            r_k <= '0;
                            r_wneg <= i_job.a_neg;
                            r_st <= ST_OK;
                            r_phase <= P_A;
                            r_state <= S_GCD;
                        end
                    end
                end
                S_GCD: begin
                    priority if (r_x == '0) begin
                        r_g <= r_y << r_k;
                        r_q <= r_m;
                        r_r <= '0;
                        r_cnt <= '0;
                        r_state <= S_DIV1;
                    end else if (r_y == '0) begin
                        r_g <= r_x << r_k;
                        r_q <= r_m;
                        r_r <= '0;
                        r_cnt <= '0;
                        r_state <= S_DIV1;
                    end else if (!r_x[0] && !r_y[0]) begin
                        r_x <= r_x >> 1;
                        r_y <= r_y >> 1;
                        r_k <= r_k + 6'd1;
                    end else if (!r_x[0]) begin
                        r_x <= r_x >> 1;
                    end else if (!r_y[0]) begin
                        r_y <= r_y >> 1;
                    end else if (r_x >= r_y) begin
                        r_x <= r_x - r_y;
                    end else begin
                        r_y <= r_y - r_x;
                    end
                end
                S_DIV1, S_DIV2: begin
                    if (r_cnt == 6'd63) begin
                        r_r <= '0;
                        r_cnt <= '0;
                        if (r_state == S_DIV1) begin
                            r_m <= {r_q[62:0], q_bit};
                            r_q <= r_d;
                            r_state <= S_DIV2;
                        end else begin
                            r_d <= {r_q[62:0], q_bit};
                            r_state <= S_NEXT;
                        end
                    end else begin
                        r_r <= q_bit ? rem_sh[63:0] - r_g : rem_sh[63:0];
                        r_q <= {r_q[62:0], q_bit};
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_NEXT: begin
                    unique case (r_phase)
                        P_A: begin
                            r_am <= r_m[MAG_W-1:0];
                            r_ad <= r_d[MAG_W-1:0];
                            r_aneg <= res_neg;
                            priority if (r_op == OP_NORM) begin
                                r_wneg <= res_neg;
                                r_state <= S_DONE;
                            end else if (r_op == OP_NEG) begin
                                r_wneg <= !res_neg && (r_m != '0);
                                r_state <= S_DONE;
                            end else if (r_op == OP_ABS) begin
                                r_wneg <= 1'b0;
                                r_state <= S_DONE;
                            end else begin
                                r_m <= 64'(r_bm_in);
                                r_d <= 64'(r_bd_in);
                                r_x <= 64'(r_bm_in);
                                r_y <= 64'(r_bd_in);
                                r_k <= '0;
                                r_wneg <= r_bneg_in;
                                r_phase <= P_B;
                                r_state <= S_GCD;
                            end
                        end
                        P_B: begin
                            r_wneg <= res_neg;
                            // division uses the reciprocal of reduced b
                            if (r_op == OP_DIV) begin
                                r_bm <= r_d[MAG_W-1:0];
                                r_bd <= r_m[MAG_W-1:0];
                            end else begin
                                r_bm <= r_m[MAG_W-1:0];
                                r_bd <= r_d[MAG_W-1:0];
                            end
                            r_bneg <= res_neg;
                            r_cnt <= '0;
                            r_state <= S_MUL;
                        end
                        default: begin
                            r_wneg <= res_neg;
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_MUL: begin
                    r_p[r_cnt[1:0]] <= 64'(mul_a) * 64'(mul_b);
                    if (r_cnt[1:0] == 2'd3) begin
                        r_cnt <= '0;
                        r_state <= S_COMB;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_COMB: begin
                    r_k <= '0;
                    r_phase <= P_R;
                    priority if (r_op == OP_CMP) begin
                        r_lt <= cmp_l < cmp_g;
                        r_eq <= cmp_l == cmp_g;
                        r_gt <= cmp_l > cmp_g;
                        r_m <= '0;
                        r_d <= '0;
                        r_wneg <= 1'b0;
                        r_state <= S_DONE;
                    end else if (r_op == OP_ADD || r_op == OP_SUB) begin
                        r_m <= add_mag;
                        r_x <= add_mag;
                        r_d <= r_p[2];
                        r_y <= r_p[2];
                        r_wneg <= add_neg;
                        r_state <= S_GCD;
                    end else begin
                        r_m <= r_p[3];
                        r_x <= r_p[3];
                        r_d <= r_p[2];
                        r_y <= r_p[2];
                        r_wneg <= r_aneg != r_bneg;
                        r_state <= S_GCD;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        o_out.valid <= 1'b1;
                        o_out.result_num <= fin_num;
                        o_out.result_den <= r_d[62:0];
                        o_out.less <= r_lt;
                        o_out.equal <= r_eq;
                        o_out.greater <= r_gt;
                        if (r_st == ST_OK && r_op != OP_CMP
                            && ((res_neg ? r_m > LIM : r_m > LIM - 64'd1)
                                || r_d > LIM - 64'd1))
                            o_out.status <= ST_WIDE;
                        else
                            o_out.status <= r_st;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `RAU_ASSERT(a_zero_den, (o_out.valid && o_out.status == ST_ZERO) |-> (o_out.result_den == '0))
    `RAU_ASSERT(a_flags, o_out.valid |-> $onehot0({o_out.less, o_out.equal, o_out.greater}))
    `RAU_ASSERT(a_gcd_nz, (r_state == S_DIV1) |-> (r_g != '0))
    `RAU_ASSERT_NEXT(a_pop_start, o_pop && !i_job.err, r_state == S_GCD)
endmodule
`default_nettype wire

### sv/rational_arithmetic_unit_top.sv
// top level of the rational arithmetic unit
//
//  channel  dir  type        payload
//  i_in     in   rau_in_if   operation, a_num, a_den, b_num, b_den
//  o_out    out  rau_out_if  result_num, result_den, less, equal, greater, status
//
// one transaction at a time in the back end; a job flagged with a zero denominator
// goes straight from idle to the result register
// run time is set by the binary gcd and two 64-step divisions, run once per operand
// used and once more for the result of add, subtract, multiply and divide
// the front end and a two-entry queue keep accepting while the back end works
// a result waiting on o_out.ready holds the back end, then the queue fills and
// i_in.ready drops
// synchronous active-low reset clears the queue, sequencer and output valid
`default_nettype none
module rational_arithmetic_unit_top import rau_pkg::*; #(
    parameter int OPERAND_BITS = 32
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    rau_in_if.sink    i_in,
    rau_out_if.source o_out
);
    // classified job from front end into queue
    t_job push_job, pop_job;
    logic push, pop, full, job_valid;

    rau_front #(.OPERAND_BITS(OPERAND_BITS)) u_front (
        .i_in   (i_in),
        .i_full (full),
        .o_push (push),
        .o_job  (push_job)
    );

    // decouples acceptance from the long-running back end
    rau_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (job_valid),
        .o_job   (pop_job)
    );

    // reduction, arithmetic and the registered result
    rau_back #(.OPERAND_BITS(OPERAND_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (pop_job),
        .o_pop       (pop),
        .o_out       (o_out)
    );
endmodule
`default_nettype wire

### test/tb.sv
// testbench of the rational arithmetic unit: checks every result against a local predictor
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import rau_pkg::*;

    localparam int OB          = 32;
    localparam int N_RANDOM    = 800;
    localparam int HOLD_CYCLES = 4000;
    localparam int DRAIN       = 1000;

    // one fraction after reduction: sign, magnitude and positive denominator
    typedef struct {
        bit        neg;
        bit [63:0] mag;
        bit [63:0] den;
    } frac_t;

    typedef struct {
        logic signed [63:0] num;
        logic [62:0]        den;
        logic               lt;
        logic               eq;
        logic               gt;
        logic [1:0]         st;
    } answer_t;

    // scoreboard: predicts each accepted transaction and checks results in order
    class rau_scoreboard;
        answer_t answers[$];
        int      n_bad;
        int      n_checked;
        int      n_op[8];
        int      n_zero;
        int      n_wide;

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            n_bad++;
        endtask

        function bit [63:0] gcd(bit [63:0] x, bit [63:0] y);
            bit [63:0] t;
            while (y != 0) begin
                t = x % y;
                x = y;
                y = t;
            end
            return x;
        endfunction

        function longint sext(logic [31:0] v);
            longint t;
            t = longint'($signed(v));
            return (t <<< (64 - OB)) >>> (64 - OB);
        endfunction

        function frac_t reduce(bit neg, bit [63:0] mag, bit [63:0] den);
            frac_t r;
            bit [63:0] g;
            g = gcd(mag, den);
            r.mag = mag / g;
            r.den = den / g;
            r.neg = neg && r.mag != 0;
            return r;
        endfunction

        function bit [63:0] magnitude(longint v);
            return v < 0 ? 64'd0 - 64'(v) : 64'(v);
        endfunction

        function frac_t to_frac(longint num, longint den);
            return reduce((num < 0) != (den < 0), magnitude(num), magnitude(den));
        endfunction

        function frac_t sum(frac_t a, frac_t b, bit minus);
            bit [63:0] t1, t2, m;
            bit n1, n2, s;
            t1 = a.mag * b.den;
            t2 = b.mag * a.den;
            n1 = a.neg;
            n2 = minus ? !b.neg : b.neg;
            if (t2 == 0) n2 = 0;
            if (n1 == n2) begin
                m = t1 + t2;
                s = n1;
            end else if (t1 >= t2) begin
                m = t1 - t2;
                s = n1;
            end else begin
                m = t2 - t1;
                s = n2;
            end
            return reduce(s, m, a.den * b.den);
        endfunction

        function frac_t product(frac_t a, frac_t b);
            return reduce(a.neg != b.neg, a.mag * b.mag, a.den * b.den);
        endfunction

        function longint with_sign(bit neg, bit [63:0] mag);
            return neg ? -longint'(mag) : longint'(mag);
        endfunction

        function void note_input(logic [2:0] op, logic [31:0] an_raw, logic [31:0] ad_raw,
                                 logic [31:0] bn_raw, logic [31:0] bd_raw);
            answer_t   e;
            longint    an, ad, bn, bd, l, g;
            bit        two;
            bit [63:0] lim;
            frac_t     a, b, r;
            an  = sext(an_raw);
            ad  = sext(ad_raw);
            bn  = sext(bn_raw);
            bd  = sext(bd_raw);
            two = op >= OP_ADD && op <= OP_CMP;
            lim = 64'd1 << (OB - 1);
            e   = '{default: '0};
            n_op[op]++;
            if (ad == 0 || (two && bd == 0) || (op == OP_DIV && bn == 0)) begin
                e.st = ST_ZERO;
                n_zero++;
                answers.push_back(e);
                return;
            end
            a = to_frac(an, ad);
            b = two ? to_frac(bn, bd) : to_frac(0, 1);
            case (op)
                OP_ADD: r = sum(a, b, 0);
                OP_SUB: r = sum(a, b, 1);
                OP_MUL: r = product(a, b);
                OP_DIV: r = product(a, to_frac(bd, bn));
                OP_CMP: begin
                    l = with_sign(a.neg, a.mag * b.den);
                    g = with_sign(b.neg, b.mag * a.den);
                    e.lt = l < g;
                    e.eq = l == g;
                    e.gt = l > g;
                    answers.push_back(e);
                    return;
                end
                OP_NEG: begin
                    r = a;
                    r.neg = !a.neg && a.mag != 0;
                end
                OP_ABS: begin
                    r = a;
                    r.neg = 0;
                end
                default: r = a;
            endcase
            e.num = r.neg ? 64'd0 - r.mag : r.mag;
            e.den = r.den[62:0];
            if ((r.neg ? r.mag > lim : r.mag > lim - 1) || r.den > lim - 1) begin
                e.st = ST_WIDE;
                n_wide++;
            end
            answers.push_back(e);
        endfunction

        task check_result(answer_t got);
            answer_t e;
            n_checked++;
            if (answers.size() == 0) begin
                report("result with no transaction outstanding");
                return;
            end
            e = answers.pop_front();
            if (got.num !== e.num)
                report($sformatf("result_num %0d, expected %0d", got.num, e.num));
            if (got.den !== e.den)
                report($sformatf("result_den %0d, expected %0d", got.den, e.den));
            if ({got.lt, got.eq, got.gt} !== {e.lt, e.eq, e.gt})
                report($sformatf("less/equal/greater %b%b%b, expected %b%b%b",
                                 got.lt, got.eq, got.gt, e.lt, e.eq, e.gt));
            if (got.st !== e.st)
                report($sformatf("status %0d, expected %0d", got.st, e.st));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    rau_in_if  in_ch();
    rau_out_if out_ch();

    rational_arithmetic_unit_top #(.OPERAND_BITS(OB)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    rau_scoreboard sb;
    int  n_sent;      // accepted input transactions
    bit  all_sent;
    bit  quiet;       // no idling on either side while set
    bit  hold;        // receiver held off to back the block up

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // idle decision shared by both sides, about 17 in 100
    function bit want_idle();
        return !quiet && $urandom_range(99) < 17;
    endfunction

    // operand values: mostly small so results stay readable, some full width
    function logic [31:0] pick_value();
        case ($urandom_range(9))
            0, 1, 2, 3: return 32'($signed($urandom_range(40)) - 20);
            4, 5:       return 32'($signed($urandom_range(2000)) - 1000);
            6, 7:       return $urandom;
            8: begin
                case ($urandom_range(4))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7fff_ffff;
                    2:       return 32'hffff_ffff;
                    3:       return 32'd1;
                    default: return 32'd0;
                endcase
            end
            default: begin
                // signed power of two, wide gcd chains
                if ($urandom_range(1)) return 32'd1 << $urandom_range(30);
                return -(32'd1 << $urandom_range(30));
            end
        endcase
    endfunction

    // offer one transaction and wait for the handshake
    task send(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
              logic [31:0] bn, logic [31:0] bd);
        bit acc;
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.a_num     <= an;
        in_ch.a_den     <= ad;
        in_ch.b_num     <= bn;
        in_ch.b_den     <= bd;
        // ready only moves at rising edges, so sample it halfway through the cycle
        do begin
            @(negedge i_clk);
            acc = in_ch.ready;
            @(posedge i_clk);
        end while (!acc);
        sb.note_input(op, an, ad, bn, bd);
        n_sent++;
        if (want_idle()) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // a den that is never zero, for the random run
    function logic [31:0] nonzero_value();
        logic [31:0] v;
        v = pick_value();
        return v == 0 ? 32'd7 : v;
    endfunction

    task run_directed();
        logic [2:0] op;
        // every operation on plain operands, negative denominator on A
        for (int k = 0; k < 8; k++) begin
            op = 3'(k);
            send(op, -32'sd6, -32'sd4, 32'sd3, 32'sd9);
        end
        // extremes of the fields
        send(OP_NORM, 32'h8000_0000, 32'hffff_ffff, 32'd0, 32'd0);   // overflows width
        send(OP_NEG,  32'h8000_0000, 32'd1, 32'd0, 32'd1);
        send(OP_ABS,  32'h8000_0000, 32'h8000_0000, 32'd0, 32'd1);
        send(OP_ADD,  32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1);
        send(OP_SUB,  32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
        send(OP_MUL,  32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1);
        send(OP_DIV,  32'd1, 32'h7fff_ffff, 32'h8000_0000, 32'd1);
        // zero denominators, on A, on B, and B unused
        send(OP_NORM, 32'd5, 32'd0, 32'd1, 32'd1);
        send(OP_ADD,  32'd5, 32'd3, 32'd1, 32'd0);
        send(OP_NEG,  32'd5, 32'd3, 32'd1, 32'd0);
        send(OP_CMP,  32'd5, 32'd3, 32'd1, 32'd0);
        // division by zero
        send(OP_DIV,  32'd5, 32'd3, 32'd0, 32'd4);
        // compare: equal after reduction, zero against negative zero, less
        send(OP_CMP,  32'd2, 32'd4, -32'sd3, -32'sd6);
        send(OP_CMP,  32'd0, 32'd5, 32'd0, -32'sd9);
        send(OP_CMP,  32'h8000_0000, 32'd1, 32'h7fff_ffff, 32'd1);
        // sum that cancels to zero, negate of zero
        send(OP_ADD,  32'd1, 32'd3, -32'sd2, 32'd6);
        send(OP_NEG,  32'd0, -32'sd7, 32'd0, 32'd1);
    endtask

    task run_random();
        logic [2:0]  op;
        logic [31:0] ad, bd;
        for (int k = 0; k < N_RANDOM; k++) begin
            quiet = k >= 300 && k < 420;
            op = 3'($urandom_range(7));
            // zero denominators stay occasional so the arithmetic gets exercised
            ad = $urandom_range(19) == 0 ? 32'd0 : nonzero_value();
            bd = $urandom_range(19) == 0 ? 32'd0 : nonzero_value();
            send(op, pick_value(), ad, pick_value(), bd);
        end
        quiet = 1'b0;
    endtask

    // sender
    initial begin
        sb = new();
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.operation <= OP_NORM;
        in_ch.a_num     <= '0;
        in_ch.a_den     <= '0;
        in_ch.b_num     <= '0;
        in_ch.b_den     <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_random();
        in_ch.valid <= 1'b0;
        all_sent = 1'b1;
    end

    // long receiver hold-off once the random part is under way, so the queue fills
    initial begin
        hold = 1'b0;
        wait (n_sent >= 60);
        @(posedge i_clk);
        hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold = 1'b0;
    end

    // receiver: sample the handshake before the edge, check it, then choose ready
    initial begin
        answer_t got;
        bit      take;
        out_ch.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            take   = i_rst_n && out_ch.valid && out_ch.ready;
            got.num = out_ch.result_num;
            got.den = out_ch.result_den;
            got.lt  = out_ch.less;
            got.eq  = out_ch.equal;
            got.gt  = out_ch.greater;
            got.st  = out_ch.status;
            @(posedge i_clk);
            if (take)
                sb.check_result(got);
            out_ch.ready <= i_rst_n && !hold && !want_idle();
        end
    end

    // end of run: drain, then summary and verdict
    initial begin
        wait (all_sent);
        while (sb.answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (sb.answers.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.answers.size()));
        $display("%0d transactions sent, %0d results checked, %0d with zero denominator,",
                 n_sent, sb.n_checked, sb.n_zero);
        $display("%0d beyond operand width; per operation: %p", sb.n_wide, sb.n_op);
        if (sb.n_bad == 0) begin
            $display("** rational_arithmetic_unit_top: PASSED **");
        end else begin
            $display("** rational_arithmetic_unit_top: FAILED **");
        end
        $finish;
    end

    // timeout: several times the expected run time of all transactions
    initial begin
        #(12_000_000);
        $display("timeout with %0d results outstanding", sb.answers.size());
        $display("** rational_arithmetic_unit_top: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire
